// ===== rtl/lkc_pkg.sv =====
// Shared types and constants for the LRU key cache.
package lkc_pkg;

    // Fixed field widths of the stream payloads
    localparam int KEY_IN_W  = 32;
    localparam int RANK_W    = 6;
    localparam int OUT_W     = 40;

    // Output tdata bit positions, lowest field first
    localparam int OUT_HIT_LSB   = 0;
    localparam int OUT_RANK_LSB  = 1;
    localparam int OUT_EVV_LSB   = 7;
    localparam int OUT_EVK_LSB   = 8;

    // Per-cycle control given to each cell
    typedef struct packed {
        logic cmp_en;   // capture the match flag against the broadcast key
        logic shift_en; // take key and valid from the neighbour in front
    } t_cell_ctrl;

endpackage

// ===== rtl/lkc_cell.sv =====
// One directory cell: a stored key, its valid bit and a registered match flag.
module lkc_cell #(
    parameter int KW = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lkc_pkg::t_cell_ctrl i_ctrl,
    input  logic [KW-1:0]      i_cmp_key,
    input  logic [KW-1:0]      i_prev_key,
    input  logic               i_prev_valid,
    output logic [KW-1:0]      o_key,
    output logic               o_valid,
    output logic               o_match
);

    logic [KW-1:0] r_key;
    logic          r_valid;
    logic          r_match;

    // Control state: valid bit and match flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctrl.cmp_en) begin
                r_match <= r_valid && (r_key == i_cmp_key);
            end
            if (i_ctrl.shift_en) begin
                r_valid <= i_prev_valid;
            end
        end
    end

    // Key payload moves one slot back on a shift
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_en) begin
            r_key <= i_prev_key;
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

// ===== rtl/lru_key_cache.sv =====
// Top level of the fully associative LRU key cache built as a row of cells.
//
//  Channel  Dir  Handshake                          Payload
//  s_axis   in   i_s_axis_tvalid / o_s_axis_tready  tdata[31:0] lookup_key
//  m_axis   out  o_m_axis_tvalid / i_m_axis_tready  tdata[39:0] hit, hit_rank,
//                                                   evicted_valid, evicted_key
//
// On acceptance every cell compares its key with the request; afterwards, in the
// busy state, the row updates its recency order.
// The next request is taken once the row has been updated, since its lookup
// depends on that order. Reset empties every cell at once; no clearing pass.
// If the result register is still occupied, the update waits in place until
// the earlier result is taken.
module lru_key_cache #(
    parameter int CAPACITY = 20,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] lookup_key
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata  // [0] hit, [6:1] hit_rank,
                                        // [7] evicted_valid, [39:8] evicted_key
);

    localparam int KW    = (KEY_BITS < lkc_pkg::KEY_IN_W) ? KEY_BITS : lkc_pkg::KEY_IN_W;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic                     r_state;
    logic                     n_state;
    logic [KW-1:0]            r_key;
    logic                     r_out_valid;
    logic [lkc_pkg::OUT_W-1:0] r_out_data;

    logic                     w_accept;
    logic                     w_update;
    logic                     w_hit;
    logic [IDX_W-1:0]         w_rank;
    logic                     w_evict;
    logic [lkc_pkg::OUT_W-1:0] w_out_data;

    logic [KW-1:0]            w_key   [CAPACITY];
    logic                     w_valid [CAPACITY];
    logic [CAPACITY-1:0]      w_match;
    lkc_pkg::t_cell_ctrl      w_ctrl  [CAPACITY];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_update        = (r_state == ST_BUSY) && (!r_out_valid || i_m_axis_tready);

    // Sequencer: compare cycle, then update cycle
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_update) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request key held for the update cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_s_axis_tdata[KW-1:0];
        end
    end

    // Keys are unique in the row, so at most one match: encode by OR
    always_comb begin
        w_rank = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_match[i]) begin
                w_rank = w_rank | IDX_W'(i);
            end
        end
    end

    assign w_hit   = |w_match;
    assign w_evict = !w_hit && w_valid[CAPACITY-1];

    // Row of cells; cell 0 takes the request key
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_ctrl[g].cmp_en   = w_accept;
        assign w_ctrl[g].shift_en = w_update && (!w_hit || (IDX_W'(g) <= w_rank));

        if (g == 0) begin : g_front
            lkc_cell #(.KW(KW)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl[g]),
                .i_cmp_key    (i_s_axis_tdata[KW-1:0]),
                .i_prev_key   (r_key),
                .i_prev_valid (1'b1),
                .o_key        (w_key[g]),
                .o_valid      (w_valid[g]),
                .o_match      (w_match[g])
            );
        end else begin : g_rest
            lkc_cell #(.KW(KW)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl[g]),
                .i_cmp_key    (i_s_axis_tdata[KW-1:0]),
                .i_prev_key   (w_key[g-1]),
                .i_prev_valid (w_valid[g-1]),
                .o_key        (w_key[g]),
                .o_valid      (w_valid[g]),
                .o_match      (w_match[g])
            );
        end
    end

    // Result word
    always_comb begin
        w_out_data = '0;
        w_out_data[lkc_pkg::OUT_HIT_LSB] = w_hit;
        w_out_data[lkc_pkg::OUT_RANK_LSB +: lkc_pkg::RANK_W] =
            lkc_pkg::RANK_W'(w_rank);
        w_out_data[lkc_pkg::OUT_EVV_LSB] = w_evict;
        if (w_evict) begin
            w_out_data[lkc_pkg::OUT_EVK_LSB +: lkc_pkg::KEY_IN_W] =
                lkc_pkg::KEY_IN_W'(w_key[CAPACITY-1]);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_out_data <= w_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/lkc_checker.sv =====
// Port-level checks for the LRU key cache, bound to the top level.
module lkc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        i_s_axis_tready,
    input logic        i_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] i_m_axis_tdata
);

    // A stalled result keeps its valid and its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && !i_m_axis_tready) |=>
            (i_m_axis_tvalid && $stable(i_m_axis_tdata)))
        else $error("result changed while stalled");

    // An accepted request occupies the block for its update cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && i_s_axis_tready) |=> !i_s_axis_tready)
        else $error("request taken during update cycle");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && i_m_axis_tdata[0]) |->
            (!i_m_axis_tdata[7] && (i_m_axis_tdata[39:8] == 32'd0)))
        else $error("eviction reported on a hit");

    // A miss reports rank zero
    a_miss_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && !i_m_axis_tdata[0]) |-> (i_m_axis_tdata[6:1] == 6'd0))
        else $error("non-zero rank on a miss");

    // No eviction means a zero evicted key
    a_no_evict_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && !i_m_axis_tdata[7]) |-> (i_m_axis_tdata[39:8] == 32'd0))
        else $error("evicted key without eviction");

endmodule

bind lru_key_cache lkc_checker u_lkc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/tb_lru_key_cache.sv =====
// Self-checking stream testbench for the LRU key cache with its own recency-order predictor.
module tb_lru_key_cache;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 20;
    localparam int KEY_BITS     = 32;
    localparam int N_LOOKUPS    = 1200;
    localparam int POOL_SIZE    = 48;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 500;
    localparam int MAX_REPORTS  = 10;
    localparam logic [lkc_pkg::KEY_IN_W-1:0] KEY_MASK =
        (KEY_BITS >= lkc_pkg::KEY_IN_W) ? '1 :
        ((lkc_pkg::KEY_IN_W'(1) << KEY_BITS) - 1);

    // One lookup outcome, fields as carried on the result stream
    typedef struct packed {
        logic                         hit;
        logic [lkc_pkg::RANK_W-1:0]   rank;
        logic                         ev_valid;
        logic [lkc_pkg::KEY_IN_W-1:0] ev_key;
    } t_lookup_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_valid = 1'b0;
    logic [lkc_pkg::KEY_IN_W-1:0] s_data = '0;
    logic                         s_ready;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [lkc_pkg::OUT_W-1:0]    m_data;

    // Pending keys, outstanding predictions
    logic [lkc_pkg::KEY_IN_W-1:0] lookup_queue[$];
    t_lookup_result               expected_results[$];

    // Predictor's copy of the directory, slot 0 most recent
    logic [lkc_pkg::KEY_IN_W-1:0] dir_key[CAPACITY];
    logic                         dir_valid[CAPACITY];
    int unsigned                  dir_count;

    int unsigned n_sent, n_checked, fail_count;
    int unsigned n_hits, n_misses, n_evictions, deepest_rank;
    int unsigned tx_gap, rx_stall, idle_cycles, hold_left;
    logic        hold_done = 1'b0;

    lru_key_cache #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),   // [31:0] lookup_key
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data)    // [0] hit, [6:1] hit_rank, [7] evicted_valid,
                                    // [39:8] evicted_key
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Wait before the next request; every third run of 64 requests has no idling
    function automatic int unsigned draw_wait(input int unsigned n);
        return ((n / 64) % 3 == 1) ? 0 : $urandom_range(0, 15);
    endfunction

    // Look the key up, update recency order, return the outcome
    function automatic t_lookup_result lru_lookup(
        input logic [lkc_pkg::KEY_IN_W-1:0] raw_key
    );
        t_lookup_result               res;
        logic [lkc_pkg::KEY_IN_W-1:0] key;
        int                           found;
        int                           last;
        key   = raw_key & KEY_MASK;
        found = CAPACITY;
        res   = '0;
        for (int i = 0; i < CAPACITY; i++)
            if (found == CAPACITY && dir_valid[i] && dir_key[i] == key)
                found = i;
        if (found < CAPACITY) begin
            res.hit  = 1'b1;
            res.rank = lkc_pkg::RANK_W'(found);
            last     = found;
            n_hits++;
            if (found > deepest_rank)
                deepest_rank = found;
        end else begin
            if (dir_count >= CAPACITY) begin
                res.ev_valid = 1'b1;
                res.ev_key   = dir_key[CAPACITY-1];
                n_evictions++;
            end else begin
                dir_count++;
            end
            last = CAPACITY - 1;
            n_misses++;
        end
        for (int i = last; i > 0; i--) begin
            dir_key[i]   = dir_key[i-1];
            dir_valid[i] = dir_valid[i-1];
        end
        dir_key[0]   = key;
        dir_valid[0] = 1'b1;
        return res;
    endfunction

    // Driver: present queued keys, predict on acceptance
    always @(posedge i_clk) begin
        logic                         next_valid;
        logic [lkc_pkg::KEY_IN_W-1:0] next_data;
        next_valid = 1'b0;
        next_data  = s_data;
        if (!i_rst_n) begin
            tx_gap = draw_wait(0);
            for (int i = 0; i < CAPACITY; i++) begin
                dir_key[i]   = '0;
                dir_valid[i] = 1'b0;
            end
            dir_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(lru_lookup(lookup_queue.pop_front()));
                n_sent++;
                tx_gap = draw_wait(n_sent);
            end
            if (s_valid && !s_ready) begin
                next_valid = 1'b1;
            end else if (tx_gap != 0) begin
                tx_gap--;
            end else if (lookup_queue.size() != 0) begin
                next_valid = 1'b1;
                next_data  = lookup_queue[0];
            end
        end
        s_valid <= next_valid;
        s_data  <= next_data;
    end

    // Long receiver hold-off, once, so the block backs up its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left = 0;
        end else if (!hold_done && n_checked == HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left--;
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_lookup_result exp_res;
        t_lookup_result got;
        if (!i_rst_n) begin
            rx_stall = draw_wait(0);
        end else begin
            if (m_valid && m_ready) begin
                got.hit      = m_data[lkc_pkg::OUT_HIT_LSB];
                got.rank     = m_data[lkc_pkg::OUT_RANK_LSB +: lkc_pkg::RANK_W];
                got.ev_valid = m_data[lkc_pkg::OUT_EVV_LSB];
                got.ev_key   = m_data[lkc_pkg::OUT_EVK_LSB +: lkc_pkg::KEY_IN_W];
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] ERROR: unexpected result %h", $realtime, m_data);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got.hit !== exp_res.hit || got.rank !== exp_res.rank ||
                        got.ev_valid !== exp_res.ev_valid ||
                        got.ev_key !== exp_res.ev_key) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("[%0t] ERROR: result %0d: exp %0d/%0d/%0d/%h got %0d/%0d/%0d/%h",
                                     $realtime, n_checked, exp_res.hit, exp_res.rank,
                                     exp_res.ev_valid, exp_res.ev_key, got.hit, got.rank,
                                     got.ev_valid, got.ev_key);
                    end
                end
                n_checked++;
                rx_stall = draw_wait(n_checked);
            end else if (rx_stall != 0) begin
                rx_stall--;
            end
        end
        m_ready <= i_rst_n && rx_stall == 0 && hold_left == 0;
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] ERROR: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [lkc_pkg::KEY_IN_W-1:0] pool[POOL_SIZE];
        int unsigned                  work_set;
        int unsigned                  pick;
        logic [lkc_pkg::KEY_IN_W-1:0] key;

        // Directed: zero key, all-ones key, front hit, fill, hit at the oldest slot,
        // then a miss on a full directory that evicts
        lookup_queue.push_back(32'h0000_0000);
        lookup_queue.push_back(32'h0000_0000);
        lookup_queue.push_back(32'hFFFF_FFFF);
        lookup_queue.push_back(32'h0000_0000);
        lookup_queue.push_back(32'hFFFF_FFFF);
        for (int i = 0; i < CAPACITY - 2; i++)
            lookup_queue.push_back(32'h1 << i);
        lookup_queue.push_back(32'h0000_0000);
        lookup_queue.push_back(32'h8000_0000);

        // Random: segments with varying working sets drawn from a key pool
        for (int j = 0; j < POOL_SIZE; j++)
            pool[j] = $urandom;
        while (lookup_queue.size() < N_LOOKUPS) begin
            case ($urandom_range(0, 6))
                0: work_set = 1;
                1: work_set = 4;
                2: work_set = 16;
                3: work_set = CAPACITY;
                4: work_set = CAPACITY + 1;
                5: work_set = CAPACITY + 4;
                default: work_set = POOL_SIZE;
            endcase
            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    key = $urandom;
                else if (pick < 13)
                    key = pool[$urandom_range(0, work_set - 1)] ^ (32'h1 << $urandom_range(0, 31));
                else
                    key = pool[$urandom_range(0, work_set - 1)];
                lookup_queue.push_back(key);
            end
            for (int j = POOL_SIZE / 2; j < POOL_SIZE; j++)
                pool[j] = $urandom;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (lookup_queue.size() != 0 || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d lookups: %0d hits (deepest rank %0d), %0d misses, %0d evictions.",
                 n_sent, n_hits, deepest_rank, n_misses, n_evictions);
        $display("Checked %0d results with one %0d-cycle output hold-off; %0d failures.",
                 n_checked, HOLD_CYCLES, fail_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
